/* hw/rtl/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg
// Types and character constants shared by the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_APOS      = 8'h27;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3f;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_0         = 8'h30;
   localparam logic [7:0] CHAR_7         = 8'h37;
   localparam logic [7:0] CHAR_8         = 8'h38;
   localparam logic [7:0] CHAR_9         = 8'h39;
   localparam logic [7:0] CHAR_LA        = 8'h61;
   localparam logic [7:0] CHAR_LB        = 8'h62;
   localparam logic [7:0] CHAR_LF        = 8'h66;
   localparam logic [7:0] CHAR_LN        = 8'h6e;
   localparam logic [7:0] CHAR_LR        = 8'h72;
   localparam logic [7:0] CHAR_LT        = 8'h74;
   localparam logic [7:0] CHAR_LV        = 8'h76;
   localparam logic [7:0] CHAR_LX        = 8'h78;
   localparam logic [7:0] CHAR_UA        = 8'h41;
   localparam logic [7:0] CHAR_UF        = 8'h46;

   localparam logic [7:0] CTRL_BEL = 8'h07;
   localparam logic [7:0] CTRL_BS  = 8'h08;
   localparam logic [7:0] CTRL_FF  = 8'h0c;
   localparam logic [7:0] CTRL_LF  = 8'h0a;
   localparam logic [7:0] CTRL_CR  = 8'h0d;
   localparam logic [7:0] CTRL_HT  = 8'h09;
   localparam logic [7:0] CTRL_VT  = 8'h0b;

   localparam int RSP_DEPTH = 4;

   typedef enum logic [3:0] {
      MODE_NORMAL = 4'b0001,
      MODE_ESCAPE = 4'b0010,
      MODE_OCTAL  = 4'b0100,
      MODE_HEX    = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       string_end;
      logic       last_of_run;
   } result_type;

   typedef struct packed {
      result_type r0;
      result_type r1;
      logic [1:0] count;
   } decode_type;

   typedef struct packed {
      logic not_empty;
      logic room_two;
   } fifo_status_type;

endpackage

/* hw/rtl/sed_decode.sv */
// ----------------------------------------------------------------------------
// sed_decode
// Escape decoding state and the per-character result logic.
// ----------------------------------------------------------------------------
module sed_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         in_char,
   output sed_pkg::decode_type dec
);

   sed_pkg::mode_type mode_ff, mode_in;
   logic [7:0]        accum_ff, accum_in;

   sed_pkg::result_type nres;
   logic [7:0]          simple_val;
   logic                simple_hit;
   logic [3:0]          hex_val;
   logic                hex_hit;
   logic                oct_hit;

   always_comb begin
      simple_hit = 1'b1;
      simple_val = in_char;
      case (in_char)
         sed_pkg::CHAR_APOS:      simple_val = sed_pkg::CHAR_APOS;
         sed_pkg::CHAR_QUOTE:     simple_val = sed_pkg::CHAR_QUOTE;
         sed_pkg::CHAR_QUESTION:  simple_val = sed_pkg::CHAR_QUESTION;
         sed_pkg::CHAR_BACKSLASH: simple_val = sed_pkg::CHAR_BACKSLASH;
         sed_pkg::CHAR_LA:        simple_val = sed_pkg::CTRL_BEL;
         sed_pkg::CHAR_LB:        simple_val = sed_pkg::CTRL_BS;
         sed_pkg::CHAR_LF:        simple_val = sed_pkg::CTRL_FF;
         sed_pkg::CHAR_LN:        simple_val = sed_pkg::CTRL_LF;
         sed_pkg::CHAR_LR:        simple_val = sed_pkg::CTRL_CR;
         sed_pkg::CHAR_LT:        simple_val = sed_pkg::CTRL_HT;
         sed_pkg::CHAR_LV:        simple_val = sed_pkg::CTRL_VT;
         default:                 simple_hit = 1'b0;
      endcase
   end

   always_comb begin
      oct_hit = in_char inside {[sed_pkg::CHAR_0 : sed_pkg::CHAR_7]};
      hex_hit = 1'b1;
      hex_val = in_char[3:0];
      if (in_char inside {[sed_pkg::CHAR_0 : sed_pkg::CHAR_9]}) begin
         hex_val = in_char[3:0];
      end else if (in_char inside {[sed_pkg::CHAR_LA : sed_pkg::CHAR_LF],
                                   [sed_pkg::CHAR_UA : sed_pkg::CHAR_UF]}) begin
         hex_val = 4'(in_char[3:0] + 4'd9);
      end else begin
         hex_hit = 1'b0;
      end
   end

   always_comb begin
      nres             = '0;
      nres.string_end  = (in_char == sed_pkg::CHAR_QUOTE);
      nres.has_byte    = !nres.string_end;
      nres.out_byte    = nres.string_end ? 8'h00 : in_char;
   end

   always_comb begin
      dec      = '0;
      mode_in  = mode_ff;
      accum_in = accum_ff;
      case (mode_ff)
         sed_pkg::MODE_ESCAPE: begin
            mode_in = sed_pkg::MODE_NORMAL;
            if (simple_hit) begin
               dec.r0    = '{out_byte: simple_val, has_byte: 1'b1,
                             string_end: 1'b0, last_of_run: 1'b0};
               dec.count = 2'd1;
            end else if (oct_hit) begin
               accum_in = {5'd0, in_char[2:0]};
               mode_in  = sed_pkg::MODE_OCTAL;
            end else if (in_char == sed_pkg::CHAR_8 || in_char == sed_pkg::CHAR_9) begin
               dec.r0    = '{out_byte: 8'h00, has_byte: 1'b1,
                             string_end: 1'b0, last_of_run: 1'b0};
               dec.r1    = nres;
               dec.count = 2'd2;
            end else if (in_char == sed_pkg::CHAR_LX) begin
               accum_in = 8'h00;
               mode_in  = sed_pkg::MODE_HEX;
            end else begin
               dec.r0    = '{out_byte: in_char, has_byte: 1'b1,
                             string_end: 1'b0, last_of_run: 1'b0};
               dec.count = 2'd1;
            end
         end
         sed_pkg::MODE_OCTAL, sed_pkg::MODE_HEX: begin
            if (mode_ff == sed_pkg::MODE_OCTAL && oct_hit && accum_ff[7:5] == 3'd0) begin
               accum_in = {accum_ff[4:0], in_char[2:0]};
            end else if (mode_ff == sed_pkg::MODE_HEX && hex_hit
                         && accum_ff[7:4] == 4'd0) begin
               accum_in = {accum_ff[3:0], hex_val};
            end else begin
               dec.r0   = '{out_byte: accum_ff, has_byte: 1'b1,
                            string_end: 1'b0, last_of_run: 1'b0};
               accum_in = 8'h00;
               if (in_char == sed_pkg::CHAR_BACKSLASH) begin
                  dec.count = 2'd1;
                  mode_in   = sed_pkg::MODE_ESCAPE;
               end else begin
                  dec.r1    = nres;
                  dec.count = 2'd2;
                  mode_in   = sed_pkg::MODE_NORMAL;
               end
            end
         end
         default: begin
            if (in_char == sed_pkg::CHAR_BACKSLASH) begin
               mode_in = sed_pkg::MODE_ESCAPE;
            end else begin
               dec.r0    = nres;
               dec.count = 2'd1;
               mode_in   = sed_pkg::MODE_NORMAL;
            end
         end
      endcase
      dec.r0.last_of_run = (dec.count == 2'd1);
      dec.r1.last_of_run = (dec.count == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= sed_pkg::MODE_NORMAL;
         accum_ff <= 8'h00;
      end else if (fire) begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
      end
   end

endmodule

/* hw/rtl/sed_result_fifo.sv */
// ----------------------------------------------------------------------------
// sed_result_fifo
// Small result queue: takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module sed_result_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                push_count,
   input  sed_pkg::result_type       data0,
   input  sed_pkg::result_type       data1,
   input  logic                      pop,
   output sed_pkg::result_type       head,
   output sed_pkg::fifo_status_type  status
);

   localparam int PTR_W = $clog2(sed_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(sed_pkg::RSP_DEPTH + 1);

   sed_pkg::result_type mem_ff [sed_pkg::RSP_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PTR_W-1:0]    wr_next;

   assign wr_next   = PTR_W'(wr_ptr_ff + 1'b1);
   assign wr_ptr_in = PTR_W'(wr_ptr_ff + push_count);
   assign rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign count_in  = CNT_W'(count_ff + CNT_W'(push_count) - CNT_W'(pop));

   assign head             = mem_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.room_two  = (count_ff <= CNT_W'(sed_pkg::RSP_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= data0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next] <= data1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/string_escape_decoder.sv */
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes the body of a C string literal, one character per item, into bytes.
// ----------------------------------------------------------------------------
// One character is taken per clock while the input is not stalled. Each
// character is held in an input register, decoded from that register, and its
// zero, one or two results are queued in a four-entry result queue that drives
// the output; a result is offered once it has been written into that queue. A
// character giving two results (a zero byte for backslash 8 or 9, or the end
// of an octal or hex escape followed by the stopping character) offers them on
// the output one after the other, so sustained throughput is one character per cycle
// when results are single, and one result per cycle otherwise; the input
// stalls only while the result queue has fewer than two free entries.
module string_escape_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] has_byte, [1] string_end
   output logic       rsp_tlast    // last_of_run
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       advance;

   sed_pkg::decode_type      dec;
   sed_pkg::result_type      head;
   sed_pkg::fifo_status_type status;
   logic [1:0]               push_count;

   assign advance     = in_valid_ff && status.room_two;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign push_count  = advance ? dec.count : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
      end
   end

   sed_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .in_char (in_char_ff),
      .dec     (dec)
   );

   sed_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .data0      (dec.r0),
      .data1      (dec.r1),
      .pop        (rsp_tvalid && rsp_tready),
      .head       (head),
      .status     (status)
   );

   assign rsp_tvalid = status.not_empty;
   assign rsp_tdata  = head.out_byte;
   assign rsp_tuser  = {head.string_end, head.has_byte};
   assign rsp_tlast  = head.last_of_run;

endmodule

/* hw/rtl/sed_checker.sv */
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks on the string escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sed_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   a_no_byte_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tuser[1] && rsp_tdata == 8'h00)
      else $error("result without a byte is not a clean string end");

   a_end_has_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && rsp_tlast)
      else $error("string end carries a byte or is not last of run");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown straight after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_tready)
      else $error("input not ready straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result item changed");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
